@@ design/simon_pkg.sv @@
// ----------------------------------------------------------------------------
// simon_pkg
// Types, constants and round functions shared by the Simon 128/128 modules.
// ----------------------------------------------------------------------------
package simon_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 8;
    localparam int Z2_LEN    = 62;
    localparam int Z2_IDX_W  = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 8'd1;

    // operation codes carried in tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // round constant c = 2^64 - 4
    localparam logic [WORD_W-1:0] KEY_CONST = 64'hFFFF_FFFF_FFFF_FFFC;

    // z2 sequence, element 0 in bit 0 of the ascending range
    localparam logic [0:Z2_LEN-1] Z2_SEQ =
        62'b10101111011100000011010010011000101000010001111110010110110011;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic expand_start;
        logic expand_step;
        logic key_wr_hi;
        logic key_wr_lo;
        logic load;
        logic round_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
    } dp_status_t;

    // f(x) = (x<<<1 & x<<<8) ^ x<<<2
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x);
        round_f = ({x[62:0], x[63]} & {x[55:0], x[63:56]}) ^ {x[61:0], x[63:62]};
    endfunction

    // key schedule mix: t = x>>>3; t ^= t>>>1
    function automatic logic [WORD_W-1:0] key_mix(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] t;
        t = {x[2:0], x[63:3]};
        key_mix = t ^ {t[0], t[63:1]};
    endfunction

endpackage

@@ design/simon_ctrl.sv @@
// ----------------------------------------------------------------------------
// simon_ctrl
// Controller: sequences key expansion, the round loop and the output handoff.
// ----------------------------------------------------------------------------
module simon_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [simon_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  simon_pkg::dp_status_t             status,
    output simon_pkg::dp_cmd_t                cmd
);

    simon_pkg::state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic              wr_hi, wr_lo, key_wr, out_free;

    // key writes only while no block is in the round loop
    assign cfg_ready = (state_reg == simon_pkg::ST_IDLE) || (state_reg == simon_pkg::ST_EXPAND);
    assign wr_hi     = cfg_valid && cfg_ready && (cfg_index == simon_pkg::REG_KEY_HI);
    assign wr_lo     = cfg_valid && cfg_ready && (cfg_index == simon_pkg::REG_KEY_LO);
    assign key_wr    = wr_hi || wr_lo;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign s_tready  = (state_reg == simon_pkg::ST_IDLE) && !key_wr;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            simon_pkg::ST_EXPAND: begin
                if (!key_wr && status.cnt_last) begin
                    state_next = simon_pkg::ST_IDLE;
                end
            end
            simon_pkg::ST_IDLE: begin
                if (key_wr) begin
                    state_next = simon_pkg::ST_EXPAND;
                end else if (s_tvalid) begin
                    state_next = simon_pkg::ST_ROUND;
                end
            end
            simon_pkg::ST_ROUND: begin
                if (status.cnt_last) begin
                    state_next = simon_pkg::ST_DONE;
                end
            end
            simon_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = simon_pkg::ST_IDLE;
                end
            end
            default: state_next = simon_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd           = '0;
        cmd.key_wr_hi = wr_hi;
        cmd.key_wr_lo = wr_lo;
        unique case (state_reg)
            simon_pkg::ST_EXPAND: begin
                cmd.expand_start = key_wr;
                cmd.expand_step  = !key_wr;
            end
            simon_pkg::ST_IDLE: begin
                cmd.expand_start = key_wr;
                cmd.load         = !key_wr && s_tvalid;
            end
            simon_pkg::ST_ROUND: begin
                cmd.round_step = 1'b1;
            end
            simon_pkg::ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= simon_pkg::ST_EXPAND;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/simon_dp.sv @@
// ----------------------------------------------------------------------------
// simon_dp
// Datapath: key registers, round key memory, key schedule and Feistel round.
// ----------------------------------------------------------------------------
module simon_dp #(
    parameter int ROUNDS = 68
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  simon_pkg::dp_cmd_t                cmd,
    output simon_pkg::dp_status_t             status,
    input  logic [simon_pkg::WORD_W-1:0]      cfg_data,
    input  logic                              in_op,
    input  logic [simon_pkg::WORD_W-1:0]      in_hi,
    input  logic [simon_pkg::WORD_W-1:0]      in_lo,
    output logic [simon_pkg::WORD_W-1:0]      out_hi,
    output logic [simon_pkg::WORD_W-1:0]      out_lo
);

    localparam int AW = $clog2(ROUNDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(ROUNDS - 1);

    logic [simon_pkg::WORD_W-1:0] rkey_mem [ROUNDS];

    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [simon_pkg::WORD_W-1:0] key_hi_reg, key_lo_reg;
    logic [simon_pkg::WORD_W-1:0] kp1_reg, kp2_reg;
    logic [simon_pkg::WORD_W-1:0] left_reg, left_next;
    logic [simon_pkg::WORD_W-1:0] right_reg, right_next;
    logic [simon_pkg::WORD_W-1:0] rkey_reg;
    logic [simon_pkg::WORD_W-1:0] res_hi_reg, res_lo_reg;
    logic                         op_reg;
    logic                         cnt_last;
    logic [AW-1:0]                raddr, zi_raw, zi;
    logic [simon_pkg::WORD_W-1:0] kw;

    assign cnt_last        = (cnt_reg == LAST_IDX);
    assign status.cnt_last = cnt_last;
    assign out_hi          = res_hi_reg;
    assign out_lo          = res_lo_reg;

    // key schedule word for the current index, z2 index taken modulo its length
    always_comb begin
        zi_raw = cnt_reg - AW'(2);
        zi     = (zi_raw >= AW'(simon_pkg::Z2_LEN)) ? zi_raw - AW'(simon_pkg::Z2_LEN)
                                                    : zi_raw;
        if (cnt_reg == AW'(0)) begin
            kw = key_lo_reg;
        end else if (cnt_reg == AW'(1)) begin
            kw = key_hi_reg;
        end else begin
            kw = kp2_reg ^ simon_pkg::key_mix(kp1_reg) ^ simon_pkg::KEY_CONST
               ^ {{(simon_pkg::WORD_W-1){1'b0}},
                  simon_pkg::Z2_SEQ[zi[simon_pkg::Z2_IDX_W-1:0]]};
        end
    end

    // read address runs one round ahead of the key in use
    always_comb begin
        if (cmd.load) begin
            raddr = (in_op == simon_pkg::OP_DECRYPT) ? LAST_IDX : AW'(0);
        end else if (cnt_last) begin
            raddr = AW'(0);
        end else if (op_reg == simon_pkg::OP_DECRYPT) begin
            raddr = LAST_IDX - cnt_reg - AW'(1);
        end else begin
            raddr = cnt_reg + AW'(1);
        end
    end

    always_comb begin
        if (op_reg == simon_pkg::OP_DECRYPT) begin
            left_next  = right_reg;
            right_next = left_reg ^ simon_pkg::round_f(right_reg) ^ rkey_reg;
        end else begin
            left_next  = right_reg ^ simon_pkg::round_f(left_reg) ^ rkey_reg;
            right_next = left_reg;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.expand_start || cmd.load) begin
            cnt_next = '0;
        end else if (cmd.expand_step || cmd.round_step) begin
            cnt_next = cnt_last ? AW'(0) : cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else begin
            if (cmd.key_wr_hi) begin
                key_hi_reg <= cfg_data;
            end
            if (cmd.key_wr_lo) begin
                key_lo_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.expand_step) begin
            rkey_mem[cnt_reg] <= kw;
            kp2_reg           <= kp1_reg;
            kp1_reg           <= kw;
        end
        rkey_reg <= rkey_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            left_reg  <= in_hi;
            right_reg <= in_lo;
        end else if (cmd.round_step) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
        if (cmd.out_load) begin
            res_hi_reg <= left_reg;
            res_lo_reg <= right_reg;
        end
    end

endmodule

@@ design/simon_128_128_cipher.sv @@
// A block is loaded into the round registers, then runs one Feistel round per cycle
// through all ROUNDS rounds, then is handed to the result register once the output is free;
// the next block is taken only after that handoff.
// Reset and every key register write run a key expansion over all ROUNDS round keys, one
// round key written per cycle unless a further key write restarts it; no input is taken meanwhile.
// Reset is synchronous on aresetn low; key registers reset to zero.
// ----------------------------------------------------------------------------
// simon_128_128_cipher
// Simon 128/128 block cipher with stored round keys, encrypt and decrypt.
// ----------------------------------------------------------------------------
module simon_128_128_cipher #(
    parameter int ROUNDS = 68
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [127:0]                      s_tdata,   // data_hi[63:0], data_lo[127:64]
    input  logic                              s_tuser,   // op[0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [127:0]                      m_tdata,   // result_hi[63:0], result_lo[127:64]
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [simon_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]      cfg_data
);

    simon_pkg::dp_cmd_t           cmd;
    simon_pkg::dp_status_t        status;
    logic [simon_pkg::WORD_W-1:0] res_hi, res_lo;

    assign m_tdata = {res_lo, res_hi};

    simon_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    simon_dp #(
        .ROUNDS (ROUNDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_data (cfg_data),
        .in_op    (s_tuser),
        .in_hi    (s_tdata[63:0]),
        .in_lo    (s_tdata[127:64]),
        .out_hi   (res_hi),
        .out_lo   (res_lo)
    );

endmodule
